FILE: rtl/core/pco_pkg.sv
// Shared types and constants of the ping clock offset estimator.
`timescale 1ns / 1ps

package pco_pkg;

	localparam int TIME_W     = 32;
	localparam int OFS_W      = 32;
	localparam int SUM_W      = 40;
	localparam int SM_W       = 35;
	localparam int TARGET_W   = 9;
	localparam int HELD_W     = 9;
	localparam int SMOOTH_DIV = 6;

	// The smoothing magnitude is at most 3*2^32, so half of it is below 2^33, and
	// for every x below 2^33 the quotient x/3 equals (x * SM_RECIP) >> 33.
	localparam int              SM_HALF_W      = SM_W - 2;
	localparam int              SM_PROD_W      = SM_HALF_W + OFS_W;
	localparam int              SM_RECIP_SHIFT = 33;
	localparam logic [OFS_W-1:0] SM_RECIP      = 32'hAAAA_AAAB;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 9'd256;

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] client_send_time;
		logic [TIME_W-1:0] server_time;
		logic [TIME_W-1:0] receive_time;
	} pco_in_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] mean_offset;
		logic signed [OFS_W-1:0] smoothed_offset;
		logic [HELD_W-1:0]       samples_held;
		logic                    is_synced;
		logic                    sample_dropped;
	} pco_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_MEAN_LD,
		ST_MEAN_DIV,
		ST_MEAN_FIX,
		ST_SM_LD,
		ST_SM_MUL,
		ST_SM_FIX,
		ST_WRITE
	} pco_state_t;

	typedef struct packed {
		logic capture;
		logic restart;
		logic accum;
		logic div_load;
		logic sm_load;
		logic sm_mul;
		logic mean_fix;
		logic smooth_fix;
		logic emit;
		logic dropped;
	} pco_cmd_t;

	typedef struct packed {
		logic full;
		logic div_done;
	} pco_stat_t;

endpackage

FILE: rtl/core/pco_if.sv
// Valid/ready stream interfaces for ping samples and estimator results.
`timescale 1ns / 1ps

interface pco_in_if;
	import pco_pkg::*;
	logic    valid;
	logic    ready;
	pco_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pco_out_if;
	import pco_pkg::*;
	logic     valid;
	logic     ready;
	pco_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/ping_clock_offset_estimator.sv
// Top level of the ping clock offset estimator.
`timescale 1ns / 1ps

// Each beat on ping carries one ping reply (client send time, server time and
// local receive time, all in milliseconds) or a restart. For a reply the block
// forms the offset server + rtt/2 - receive, adds it to a 40-bit running sum
// and bumps the sample count, then reports the rounded mean of all samples and
// a smoothed offset (5*old + mean)/6; once the count reaches the programmed
// sync_sample_target, is_synced rises and the smoothed offset snaps to the
// mean. A restart clears the sum, the count and the synced flag but keeps the
// last mean and smoothed values. A reply that arrives while MAX_SAMPLES
// samples are already held changes nothing and comes back flagged as dropped.
// Every input beat produces exactly one result beat. For a reply the block
// captures the offset, adds it to the sum, forms the mean, where a restoring
// divider resolves one of 40 quotient bits per cycle, and then the smoothing,
// where the magnitude of 5*old + mean is halved and multiplied by the
// reciprocal of three, before its result is loaded. A restart or a dropped
// reply goes straight to loading its result, with no arithmetic. The next
// beat is accepted as soon as the previous result has been loaded into the
// output register, even if the consumer has not taken it yet.
// The target register is written with cfg_wr_en and should only be changed
// while the block is idle.

module ping_clock_offset_estimator #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pco_pkg::TARGET_W-1:0] cfg_wr_data,
	pco_in_if.sink                       ping,
	pco_out_if.source                    result
);
	import pco_pkg::*;

	pco_cmd_t  cmd;
	pco_stat_t stat;
	logic      in_ready;
	logic      out_valid;
	pco_out_t  out_payload;

	// The controller owns both handshakes; the datapath only sees the payload.
	pco_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ping.valid),
		.in_opcode (ping.payload.opcode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pco_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (ping.payload),
		.cmd         (cmd),
		.stat        (stat),
		.result      (out_payload)
	);

	assign ping.ready     = in_ready;
	assign result.valid   = out_valid;
	assign result.payload = out_payload;

endmodule

FILE: rtl/core/pco_div.sv
// Restoring unsigned divider, one quotient bit per cycle, for the mean offset.
`timescale 1ns / 1ps

module pco_div #(
	parameter int DIV_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [pco_pkg::SUM_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [pco_pkg::SUM_W-1:0] quotient,
	output logic [DIV_W-1:0]          remainder
);
	import pco_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [DIV_W:0]    partial;
	logic [DIV_W+1:0]  diff;
	logic              fits;

	always_comb begin
		partial = {rem_q, quo_q[SUM_W-1]};
		diff    = {1'b0, partial} - {2'b00, divisor_q};
		fits    = !diff[DIV_W+1];
	end

	assign done      = busy_q && (step_q == STEP_W'(SUM_W - 1));
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			busy_q <= !done;
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
		end
	end

endmodule

FILE: rtl/core/pco_datapath.sv
// Offset datapath: sample capture, running sum and count, mean and smoothed offset.
`timescale 1ns / 1ps

module pco_datapath #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pco_pkg::TARGET_W-1:0] cfg_wr_data,
	input  pco_pkg::pco_in_t             sample,
	input  pco_pkg::pco_cmd_t            cmd,
	output pco_pkg::pco_stat_t           stat,
	output pco_pkg::pco_out_t            result
);
	import pco_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

	logic [TARGET_W-1:0]     target_q;
	logic [OFS_W-1:0]        delta_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [OFS_W-1:0] mean_q;
	logic signed [OFS_W-1:0] smooth_q;
	logic                    synced_q;
	logic                    neg_q;
	logic [SM_HALF_W-1:0]    sm_half_q;
	logic                    sm_neg_q;
	logic [OFS_W-1:0]        sm_quo_q;
	pco_out_t                result_q;

	logic [TIME_W-1:0]       rtt;
	logic [SUM_W-1:0]        sum_mag;
	logic signed [SM_W-1:0]  sm_mix;
	logic [SM_W-1:0]         sm_mag;
	logic [SM_PROD_W-1:0]    sm_prod;
	logic [OFS_W-1:0]        sm_signed;
	logic                    div_done;
	logic [SUM_W-1:0]        quo;
	logic [CNT_W-1:0]        rem;
	logic [SUM_W-1:0]        q_signed;
	logic                    q_neg;
	logic                    round_up;
	logic [SUM_W-1:0]        q_round;
	logic                    reached;

	assign rtt = sample.receive_time - sample.client_send_time;

	always_comb begin
		sum_mag   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
		sm_mix    = (SM_W'(smooth_q) <<< 2) + SM_W'(smooth_q) + SM_W'(mean_q);
		sm_mag    = sm_mix[SM_W-1] ? (~sm_mix + SM_W'(1)) : sm_mix;
		sm_prod   = {{OFS_W{1'b0}}, sm_half_q} * {{SM_HALF_W{1'b0}}, SM_RECIP};
		sm_signed = sm_neg_q ? (~sm_quo_q + OFS_W'(1)) : sm_quo_q;
	end

	pco_div #(.DIV_W(CNT_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.div_load),
		.dividend  (sum_mag),
		.divisor   (count_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// A zero quotient counts as non-negative, so rounding moves it to +1.
	always_comb begin
		q_signed = neg_q ? (~quo + SUM_W'(1)) : quo;
		q_neg    = neg_q && (quo != '0);
		round_up = rem > (count_q >> 1);
		if (!round_up) begin
			q_round = q_signed;
		end else if (q_neg) begin
			q_round = q_signed - SUM_W'(1);
		end else begin
			q_round = q_signed + SUM_W'(1);
		end
		reached = !synced_q && (CMP_W'(count_q) >= CMP_W'(target_q));
	end

	assign stat.full     = (count_q == CNT_W'(MAX_SAMPLES));
	assign stat.div_done = div_done;
	assign result        = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			sum_q    <= '0;
			count_q  <= '0;
			mean_q   <= '0;
			smooth_q <= '0;
			synced_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (cmd.restart) begin
				sum_q    <= '0;
				count_q  <= '0;
				synced_q <= 1'b0;
			end else if (cmd.accum) begin
				sum_q   <= sum_q + {{(SUM_W - OFS_W){delta_q[OFS_W-1]}}, delta_q};
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.mean_fix) begin
				mean_q <= q_round[OFS_W-1:0];
			end
			if (cmd.smooth_fix) begin
				if (reached) begin
					synced_q <= 1'b1;
					smooth_q <= mean_q;
				end else begin
					smooth_q <= sm_signed;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			delta_q <= sample.server_time + (rtt >> 1) - sample.receive_time;
		end
		if (cmd.div_load) begin
			neg_q <= sum_q[SUM_W-1];
		end
		// Divide by six: halve the magnitude, then multiply by the reciprocal of three.
		if (cmd.sm_load) begin
			sm_half_q <= sm_mag[SM_W-2:1];
			sm_neg_q  <= sm_mix[SM_W-1];
		end
		if (cmd.sm_mul) begin
			sm_quo_q <= sm_prod[SM_RECIP_SHIFT +: OFS_W];
		end
		if (cmd.emit) begin
			result_q.mean_offset     <= mean_q;
			result_q.smoothed_offset <= smooth_q;
			result_q.samples_held    <= HELD_W'(count_q);
			result_q.is_synced       <= synced_q;
			result_q.sample_dropped  <= cmd.dropped;
		end
	end

endmodule

FILE: rtl/core/pco_ctrl.sv
// Sequencing controller: input and output handshakes and datapath commands.
`timescale 1ns / 1ps

module pco_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pco_pkg::pco_stat_t stat,
	output pco_pkg::pco_cmd_t  cmd
);
	import pco_pkg::*;

	pco_state_t state_q;
	pco_state_t state_n;
	logic       drop_q;
	logic       drop_n;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			drop_q  <= drop_n;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		drop_n  = drop_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_opcode == OP_RESTART) begin
						cmd.restart = 1'b1;
						drop_n      = 1'b0;
						state_n     = ST_WRITE;
					end else if (stat.full) begin
						drop_n  = 1'b1;
						state_n = ST_WRITE;
					end else begin
						cmd.capture = 1'b1;
						drop_n      = 1'b0;
						state_n     = ST_ACCUM;
					end
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_n   = ST_MEAN_LD;
			end
			ST_MEAN_LD: begin
				cmd.div_load = 1'b1;
				state_n      = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				if (stat.div_done) begin
					state_n = ST_MEAN_FIX;
				end
			end
			ST_MEAN_FIX: begin
				cmd.mean_fix = 1'b1;
				state_n      = ST_SM_LD;
			end
			ST_SM_LD: begin
				cmd.sm_load = 1'b1;
				state_n     = ST_SM_MUL;
			end
			ST_SM_MUL: begin
				cmd.sm_mul = 1'b1;
				state_n    = ST_SM_FIX;
			end
			ST_SM_FIX: begin
				cmd.smooth_fix = 1'b1;
				state_n        = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.dropped = drop_q;
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/pco_checker.sv
// Port-level assertions for the ping clock offset estimator, bound to the top level.
`timescale 1ns / 1ps

module pco_checker #(
	parameter int MAX_SAMPLES = 256
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       ping_valid,
	input logic                       ping_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic [pco_pkg::HELD_W-1:0] samples_held,
	input logic                       is_synced,
	input logic                       sample_dropped,
	input pco_pkg::pco_out_t          payload
);
	import pco_pkg::*;

	// A stalled result beat stays up and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(payload))
		else $error("result beat changed while stalled");

	// The block is busy in the cycle after every accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		ping_valid && ping_ready |=> !ping_ready)
		else $error("ping accepted in back-to-back cycles");

	// A dropped sample is only reported when the store is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sample_dropped |-> samples_held == HELD_W'(MAX_SAMPLES))
		else $error("sample dropped while the store was not full");

	// Synchronization needs at least one held sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_synced && (MAX_SAMPLES < 512) |-> samples_held != '0)
		else $error("synced reported with no samples held");

endmodule

bind ping_clock_offset_estimator pco_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_pco_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.ping_valid     (ping.valid),
	.ping_ready     (ping.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.samples_held   (result.payload.samples_held),
	.is_synced      (result.payload.is_synced),
	.sample_dropped (result.payload.sample_dropped),
	.payload        (result.payload)
);

FILE: sim/tb_ping_clock_offset_estimator.sv
// Self-checking testbench for the ping clock offset estimator.
`timescale 1ns / 1ps

// Ping reply beats and restarts are queued by the stimulus process. A driver
// offers them on the ping channel with random gaps. A monitor predicts one
// report for every accepted ping beat and compares each report beat, field by
// field, with the oldest prediction. The run starts with a short directed part
// that covers the time extremes and the rounding corners. Random sessions
// follow, each under its own sync target. One session is long enough to fill
// the sample store, and during it the consumer stalls for a long stretch.
module tb_ping_clock_offset_estimator;
	import pco_pkg::*;

	localparam int MAX_SAMPLES   = 256;
	localparam int GAP_PCT       = 32;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 100;
	localparam int ITEM_BUDGET   = 1200;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [TARGET_W-1:0] cfg_wr_data;

	pco_in_if  ping_if ();
	pco_out_if result_if ();

	ping_clock_offset_estimator #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ping       (ping_if),
		.result     (result_if)
	);

	// Beats waiting to be offered, and reports predicted but not yet seen.
	pco_in_t  pending_pings[$];
	pco_out_t expected_reports[$];

	int mismatches;
	int total_items;
	bit gaps_on;
	bit ping_taken;
	bit hold_req;
	int hold_left;

	// Our own copy of the estimator state and its target register.
	logic signed [SUM_W-1:0] est_sum;
	logic [HELD_W-1:0]       est_count;
	logic signed [OFS_W-1:0] est_mean;
	logic signed [OFS_W-1:0] est_smooth;
	logic                    est_synced;
	logic [TARGET_W-1:0]     est_target;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the report that one accepted ping beat produces and advances
	// the predicted state to match.
	function automatic pco_out_t estimate_offset(pco_in_t b);
		logic [TIME_W-1:0] rtt;
		logic [TIME_W-1:0] delta;
		longint s, c, q, r, sm;
		bit dropped;
		pco_out_t rep;
		dropped = 1'b0;
		if (b.opcode == OP_RESTART) begin
			// A restart forgets the samples but keeps the last mean and smoothed value.
			est_sum = '0;
			est_count = '0;
			est_synced = 1'b0;
		end else if (est_count >= HELD_W'(MAX_SAMPLES)) begin
			// Store full: nothing changes and the reply is flagged as dropped.
			dropped = 1'b1;
		end else begin
			rtt = b.receive_time - b.client_send_time;
			delta = b.server_time + (rtt >> 1) - b.receive_time;
			est_sum = est_sum + {{(SUM_W - TIME_W){delta[TIME_W-1]}}, delta};
			est_count = est_count + HELD_W'(1);
			s = longint'(est_sum);
			c = longint'(est_count);
			q = s / c;
			r = s % c;
			if (r < 0)
				r = -r;
			// Round away from zero past the half, except that a zero quotient
			// always steps up to +1 whatever the sign of the sum.
			if (r > c / 2)
				q = (q < 0) ? q - 1 : q + 1;
			est_mean = OFS_W'(q);
			sm = (longint'(est_smooth) * longint'(SMOOTH_DIV - 1) + longint'(est_mean))
				/ longint'(SMOOTH_DIV);
			est_smooth = OFS_W'(sm);
			// On reaching the target the smoothed value snaps to the mean.
			if (!est_synced && est_count >= est_target) begin
				est_synced = 1'b1;
				est_smooth = est_mean;
			end
		end
		rep.mean_offset = est_mean;
		rep.smoothed_offset = est_smooth;
		rep.samples_held = est_count;
		rep.is_synced = est_synced;
		rep.sample_dropped = dropped;
		return rep;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Monitor: everything is sampled at the rising edge, before the block's
	// registers move.
	always @(posedge clk) begin
		pco_out_t want;
		if (arst_n) begin
			if (ping_if.valid && ping_if.ready) begin
				ping_taken = 1'b1;
				expected_reports.push_back(estimate_offset(ping_if.payload));
			end
			if (result_if.valid && result_if.ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					$display("%0t ns: unexpected report beat, expected none, actual %p",
						$time, result_if.payload);
				end else begin
					want = expected_reports.pop_front();
					check_field("mean_offset", longint'(want.mean_offset),
						longint'(result_if.payload.mean_offset));
					check_field("smoothed_offset", longint'(want.smoothed_offset),
						longint'(result_if.payload.smoothed_offset));
					check_field("samples_held", longint'(want.samples_held),
						longint'(result_if.payload.samples_held));
					check_field("is_synced", longint'(want.is_synced),
						longint'(result_if.payload.is_synced));
					check_field("sample_dropped", longint'(want.sample_dropped),
						longint'(result_if.payload.sample_dropped));
				end
			end
		end
	end

	// Driver: a beat stays on the channel until it is taken; only then may the
	// next one follow, possibly after a gap.
	always @(negedge clk) begin
		if (arst_n && (!ping_if.valid || ping_taken)) begin
			ping_taken = 1'b0;
			if (pending_pings.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
				ping_if.valid <= 1'b1;
				ping_if.payload <= pending_pings.pop_front();
			end else begin
				ping_if.valid <= 1'b0;
			end
		end
	end

	// Consumer: random stalls, plus one long hold-off on request that is counted
	// here cycle by cycle. During the hold-off the block fills up and must stop
	// taking ping beats.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_if.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
		end
	end

	// A ping reply built from explicit timer values.
	function automatic pco_in_t ping_beat(logic [TIME_W-1:0] send, logic [TIME_W-1:0] srv,
		logic [TIME_W-1:0] recv);
		pco_in_t b;
		b.opcode = OP_SAMPLE;
		b.client_send_time = send;
		b.server_time = srv;
		b.receive_time = recv;
		return b;
	endfunction

	// A ping reply whose offset comes out as ofs, with a random send time and
	// round trip.
	function automatic pco_in_t ping_with_offset(logic [OFS_W-1:0] ofs);
		logic [TIME_W-1:0] send;
		logic [TIME_W-1:0] rtt;
		send = $urandom;
		rtt = $urandom_range(0, 1000);
		return ping_beat(send, send + rtt - (rtt >> 1) + ofs, send + rtt);
	endfunction

	// The time fields of a restart are don't-care, so they carry noise.
	function automatic pco_in_t restart_beat();
		pco_in_t b;
		b = ping_beat($urandom, $urandom, $urandom);
		b.opcode = OP_RESTART;
		return b;
	endfunction

	task automatic queue_beat(pco_in_t b);
		pending_pings.push_back(b);
		total_items++;
	endtask

	// A session opens with a restart and then carries mostly plausible replies:
	// small round trips and offsets either near zero or anywhere at all. A few
	// restarts and replies with arbitrary timer values are mixed in.
	task automatic queue_session(int n, int restart_pct);
		int roll;
		queue_beat(restart_beat());
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < restart_pct)
				queue_beat(restart_beat());
			else if (roll < restart_pct + 9)
				queue_beat(ping_beat($urandom, $urandom, $urandom));
			else if (roll < 60)
				queue_beat(ping_with_offset($urandom_range(0, 4000) - 2000));
			else
				queue_beat(ping_with_offset($urandom));
		end
	endtask

	// Waits until every beat has been offered, taken and answered.
	task automatic wait_drained();
		while (pending_pings.size() != 0 || ping_if.valid || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	// The target register may only change while the block is idle.
	task automatic write_target(logic [TARGET_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		est_target = value;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		ping_if.valid = 1'b0;
		ping_if.payload = '0;
		result_if.ready = 1'b0;
		mismatches = 0;
		total_items = 0;
		gaps_on = 1'b1;
		ping_taken = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		est_sum = '0;
		est_count = '0;
		est_mean = '0;
		est_smooth = '0;
		est_synced = 1'b0;
		est_target = TARGET_RESET;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under a target of three samples.
		write_target(TARGET_W'(3));
		queue_beat(restart_beat());
		// Sum -2 over three samples: the zero quotient is pushed to +1, and
		// the third sample reaches the target.
		queue_beat(ping_with_offset(-1));
		queue_beat(ping_with_offset(-1));
		queue_beat(ping_with_offset(0));
		// Sum -17 over three samples rounds away from zero to -6; one more
		// sample keeps the block synced.
		queue_beat(restart_beat());
		queue_beat(ping_with_offset(-5));
		queue_beat(ping_with_offset(-6));
		queue_beat(ping_with_offset(-6));
		queue_beat(ping_with_offset(7));
		// Timer extremes: the largest and smallest offsets, all zeros, all
		// ones, and a receive time that wrapped past the send time.
		queue_beat(restart_beat());
		queue_beat(ping_beat('0, '1, '1));
		queue_beat(ping_beat('1, 32'h8000_0000, '0));
		queue_beat(ping_beat('0, '0, '0));
		queue_beat(ping_beat('1, '1, '1));
		queue_beat(ping_beat('1, '0, '0));
		// Sum 5 over three samples rounds up to 2.
		queue_beat(restart_beat());
		queue_beat(ping_with_offset(1));
		queue_beat(ping_with_offset(2));
		queue_beat(ping_with_offset(2));

		// Top target with a session long enough to fill the store and drop
		// replies; the consumer stalls at length while the driver keeps offering.
		wait_drained();
		write_target(TARGET_RESET);
		queue_session(290, 0);
		@(posedge clk);
		hold_req = 1'b1;

		// Target of one, in a stretch with no gaps on either side.
		wait_drained();
		write_target(TARGET_W'(1));
		gaps_on = 1'b0;
		queue_session(120, 4);

		// A target of zero counts as reached already; a target above the store size
		// is never reached.
		wait_drained();
		gaps_on = 1'b1;
		write_target(TARGET_W'(0));
		queue_session(60, 4);
		wait_drained();
		write_target(TARGET_W'($urandom_range(MAX_SAMPLES + 1, 511)));
		queue_session(80, 4);

		// Random targets, mostly small so that synchronization happens often.
		while (total_items < ITEM_BUDGET) begin
			wait_drained();
			if ($urandom_range(1))
				write_target(TARGET_W'($urandom_range(1, 16)));
			else
				write_target(TARGET_W'($urandom_range(1, MAX_SAMPLES)));
			queue_session($urandom_range(40, 150), 3);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("ping_clock_offset_estimator regression: pass");
		else
			$display("ping_clock_offset_estimator regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("ping_clock_offset_estimator regression: fail");
		$finish;
	end

endmodule
